// ----- design/deq_pkg.sv -----
// Shared types and constants for the indexed double-ended queue.
package deq_pkg;

  localparam int Depth     = 64;
  localparam int WordBits  = 32;
  localparam int AddrBits  = $clog2(Depth);
  localparam int CountBits = $clog2(Depth + 1);

  localparam logic [1:0] ModePushBack = 2'd0;
  localparam logic [1:0] ModePopFront = 2'd1;
  localparam logic [1:0] ModePopBack  = 2'd2;
  localparam logic [1:0] ModeReadAt   = 2'd3;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;
  localparam logic [1:0] StatRange = 2'd3;

  typedef struct packed {
    logic [1:0]                  mode;
    logic signed [WordBits-1:0]  value;
    logic [AddrBits-1:0]         index;
  } req_t;

  typedef struct packed {
    logic signed [WordBits-1:0]  read_value;
    logic signed [WordBits-1:0]  front_value;
    logic signed [WordBits-1:0]  back_value;
    logic [CountBits-1:0]        count;
    logic [1:0]                  status;
  } rsp_t;

endpackage

// ----- design/deq_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/double_ended_queue_indexed.sv -----
// An accepted request is held in the request register through the wait state, and its
// result is then registered into the output register. A request is taken only in the
// idle state with no untaken result held; the wait state covers the registered RAM read.
// Front and back words are cached in registers, so each request reads at most one entry.
// Reset clears front slot, count, cached ends and handshake state; the RAM is not cleared.
module double_ended_queue_indexed (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  deq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output deq_pkg::rsp_t out_data_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StWait = 1'b1;

  logic                              state_q, state_d;
  logic [deq_pkg::AddrBits-1:0]      front_slot_q, front_slot_d;
  logic [deq_pkg::CountBits-1:0]     count_q, count_d;
  logic signed [deq_pkg::WordBits-1:0] front_val_q, front_val_d;
  logic signed [deq_pkg::WordBits-1:0] back_val_q, back_val_d;
  deq_pkg::req_t                     req_q, req_d;
  logic [1:0]                        stat_q, stat_d;
  logic                              out_valid_q, out_valid_d;
  deq_pkg::rsp_t                     out_data_q, out_data_d;

  logic                              in_fire;
  logic                              ram_we;
  logic [deq_pkg::AddrBits-1:0]      ram_waddr, ram_raddr;
  logic [deq_pkg::WordBits-1:0]      ram_rdata;
  logic                              not_empty;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign not_empty  = (count_q != '0);

  deq_ram #(
    .Width(deq_pkg::WordBits),
    .Depth(deq_pkg::Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_data_i.value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Accept side: check the request, move pointers, issue the one RAM access.
  always_comb begin
    state_d      = state_q;
    front_slot_d = front_slot_q;
    count_d      = count_q;
    req_d        = req_q;
    stat_d       = stat_q;
    ram_we       = 1'b0;
    ram_waddr    = front_slot_q + count_q[deq_pkg::AddrBits-1:0];
    ram_raddr    = front_slot_q;
    if (state_q == StIdle) begin
      if (in_fire) begin
        req_d   = in_data_i;
        stat_d  = deq_pkg::StatOk;
        state_d = StWait;
        unique case (in_data_i.mode)
          deq_pkg::ModePushBack: begin
            if (count_q == deq_pkg::CountBits'(deq_pkg::Depth)) begin
              stat_d = deq_pkg::StatFull;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          deq_pkg::ModePopFront: begin
            if (!not_empty) begin
              stat_d = deq_pkg::StatEmpty;
            end else begin
              front_slot_d = front_slot_q + 1'b1;
              count_d      = count_q - 1'b1;
              ram_raddr    = front_slot_q + 1'b1;
            end
          end
          deq_pkg::ModePopBack: begin
            if (!not_empty) begin
              stat_d = deq_pkg::StatEmpty;
            end else begin
              count_d   = count_q - 1'b1;
              // new back slot; meaningless when the queue drains, result is zeroed then
              ram_raddr = front_slot_q
                        + deq_pkg::AddrBits'(count_q - deq_pkg::CountBits'(2));
            end
          end
          deq_pkg::ModeReadAt: begin
            if (deq_pkg::CountBits'(in_data_i.index) >= count_q) begin
              stat_d = deq_pkg::StatRange;
            end else begin
              ram_raddr = front_slot_q + in_data_i.index;
            end
          end
          default: begin
            stat_d = deq_pkg::StatOk;
          end
        endcase
      end
    end else begin
      state_d = StIdle;
    end
  end

  // Result side: combine RAM data with the cached ends, refresh the cache.
  always_comb begin
    front_val_d = front_val_q;
    back_val_d  = back_val_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == StWait) begin
      out_data_d.read_value = '0;
      if (stat_q == deq_pkg::StatOk) begin
        case (req_q.mode)
          deq_pkg::ModePushBack: begin
            back_val_d = req_q.value;
            if (count_q == deq_pkg::CountBits'(1)) begin
              front_val_d = req_q.value;
            end
          end
          deq_pkg::ModePopFront: begin
            out_data_d.read_value = front_val_q;
            front_val_d = not_empty ? ram_rdata : '0;
            back_val_d  = not_empty ? back_val_q : '0;
          end
          deq_pkg::ModePopBack: begin
            out_data_d.read_value = back_val_q;
            back_val_d  = not_empty ? ram_rdata : '0;
            front_val_d = not_empty ? front_val_q : '0;
          end
          default: begin
            out_data_d.read_value = ram_rdata;
          end
        endcase
      end
      out_data_d.front_value = front_val_d;
      out_data_d.back_value  = back_val_d;
      out_data_d.count       = count_q;
      out_data_d.status      = stat_q;
      out_valid_d            = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      front_slot_q <= '0;
      count_q      <= '0;
      front_val_q  <= '0;
      back_val_q   <= '0;
      stat_q       <= deq_pkg::StatOk;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_slot_q <= front_slot_d;
      count_q      <= count_d;
      front_val_q  <= front_val_d;
      back_val_q   <= back_val_d;
      stat_q       <= stat_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= deq_pkg::CountBits'(deq_pkg::Depth))
    else $error("element count above depth");

  a_wait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWait |-> !out_valid_q)
    else $error("result register busy while a request completes");

  a_accept_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ##1 out_valid_q)
    else $error("accepted request produced no result");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.mode == deq_pkg::ModePushBack
      && count_q != deq_pkg::CountBits'(deq_pkg::Depth)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not advance the count");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the indexed double-ended queue.
module tb_top;
  import deq_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int RxHoldCycles  = 300;
  localparam int TailCycles    = 10;
  localparam int MaxReports    = 10;
  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef struct packed {
    req_t req;
    logic known;
    rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  // Shadow copy of the ring, its front slot and its fill level
  logic signed [WordBits-1:0] shadow_ring [Depth];
  logic [AddrBits-1:0]        shadow_head;
  logic [CountBits-1:0]       shadow_fill;

  rsp_t due_rsp [$];
  rsp_t head_rsp;

  logic quiet       = 1'b0;
  logic rx_hold_req = 1'b0;
  int   mismatches  = 0;
  int   sent        = 0;
  int   received    = 0;
  int   empty_pops  = 0;
  int   full_pushes = 0;
  int   range_reads = 0;
  int   peak_fill   = 0;
  int   idle_cycles = 0;

  dir_row_t dir_rows [21] = '{
    '{'{ModePopFront, 32'sd5, 6'd0}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 7'd0, StatEmpty}},
    '{'{ModePopBack, -32'sd1, 6'd63}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 7'd0, StatEmpty}},
    '{'{ModeReadAt, 32'sd0, 6'd0}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 7'd0, StatRange}},
    '{'{ModePushBack, WordMax, 6'd63}, 1'b1,
      '{32'sd0, WordMax, WordMax, 7'd1, StatOk}},
    '{'{ModePushBack, WordMin, 6'd0}, 1'b1,
      '{32'sd0, WordMax, WordMin, 7'd2, StatOk}},
    '{'{ModeReadAt, 32'sd0, 6'd0}, 1'b1,
      '{WordMax, WordMax, WordMin, 7'd2, StatOk}},
    '{'{ModeReadAt, -32'sd1, 6'd1}, 1'b1,
      '{WordMin, WordMax, WordMin, 7'd2, StatOk}},
    '{'{ModeReadAt, 32'sd0, 6'd2}, 1'b1,
      '{32'sd0, WordMax, WordMin, 7'd2, StatRange}},
    '{'{ModeReadAt, WordMin, 6'd63}, 1'b1,
      '{32'sd0, WordMax, WordMin, 7'd2, StatRange}},
    '{'{ModePopFront, WordMax, 6'd63}, 1'b1,
      '{WordMax, WordMin, WordMin, 7'd1, StatOk}},
    '{'{ModePopBack, 32'sd0, 6'd0}, 1'b1,
      '{WordMin, 32'sd0, 32'sd0, 7'd0, StatOk}},
    '{'{ModePopFront, 32'sd7, 6'd42}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 7'd0, StatEmpty}},
    '{'{ModePushBack, 32'sd0, 6'd21}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 7'd1, StatOk}},
    '{'{ModePushBack, -32'sd1, 6'd0}, 1'b0, '0},
    '{'{ModePushBack, 32'sd1, 6'd0}, 1'b0, '0},
    '{'{ModeReadAt, 32'sd0, 6'd2}, 1'b0, '0},
    '{'{ModeReadAt, 32'sd0, 6'd3}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd1, 7'd3, StatRange}},
    '{'{ModePopBack, 32'sd9, 6'd1}, 1'b0, '0},
    '{'{ModePopFront, 32'sd0, 6'd0}, 1'b0, '0},
    '{'{ModePopFront, 32'sd0, 6'd0}, 1'b1,
      '{-32'sd1, 32'sd0, 32'sd0, 7'd0, StatOk}},
    '{'{ModeReadAt, 32'sd0, 6'd0}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 7'd0, StatRange}}
  };

  double_ended_queue_indexed uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the shadow queue and return the response it yields.
  function automatic rsp_t deque_op(input req_t r);
    rsp_t o;
    logic [AddrBits-1:0] slot;
    o = '0;
    case (r.mode)
      ModePushBack: begin
        if (shadow_fill == CountBits'(Depth)) begin
          o.status = StatFull;
        end else begin
          slot = shadow_head + AddrBits'(shadow_fill);
          shadow_ring[slot] = r.value;
          shadow_fill = shadow_fill + 1'b1;
        end
      end
      ModePopFront: begin
        if (shadow_fill == 0) begin
          o.status = StatEmpty;
        end else begin
          o.read_value = shadow_ring[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_fill = shadow_fill - 1'b1;
        end
      end
      ModePopBack: begin
        if (shadow_fill == 0) begin
          o.status = StatEmpty;
        end else begin
          slot = shadow_head + AddrBits'(shadow_fill - 1'b1);
          o.read_value = shadow_ring[slot];
          shadow_fill = shadow_fill - 1'b1;
        end
      end
      default: begin
        if (CountBits'(r.index) >= shadow_fill) begin
          o.status = StatRange;
        end else begin
          slot = shadow_head + r.index;
          o.read_value = shadow_ring[slot];
        end
      end
    endcase
    if (shadow_fill != 0) begin
      o.front_value = shadow_ring[shadow_head];
      slot = shadow_head + AddrBits'(shadow_fill - 1'b1);
      o.back_value = shadow_ring[slot];
    end
    o.count = shadow_fill;
    return o;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Offer one request; valid stays high after acceptance until the next call
  // raises it again with new data or the caller drops it.
  task automatic send_request(input req_t r, input logic known, input rsp_t typed);
    int   gap;
    rsp_t want;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
    want = deque_op(r);
    due_rsp.push_back(known ? typed : want);
    sent++;
  endtask

  task automatic run_phase(input int n, input int push_w, input int popf_w,
                           input int popb_w);
    req_t r;
    int   roll;
    for (int k = 0; k < n; k++) begin
      r.value = $urandom;
      if ($urandom_range(0, 9) == 0) r.value = $urandom_range(0, 1) ? WordMax : WordMin;
      r.index = AddrBits'($urandom_range(0, Depth - 1));
      roll = $urandom_range(0, 99);
      if (roll < push_w) begin
        r.mode = ModePushBack;
      end else if (roll < push_w + popf_w) begin
        r.mode = ModePopFront;
      end else if (roll < push_w + popf_w + popb_w) begin
        r.mode = ModePopBack;
      end else begin
        r.mode = ModeReadAt;
        // keep most reads inside the stored range
        if (shadow_fill != 0 && $urandom_range(0, 99) < 85)
          r.index = AddrBits'($urandom_range(0, shadow_fill - 1));
      end
      send_request(r, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string field, input logic [WordBits-1:0] want,
                             input logic [WordBits-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: response %0d %s expected 'h%0h got 'h%0h",
                 $time, received, field, want, got);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    shadow_head = '0;
    shadow_fill = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);

    // Fill to the top and beyond; the receiver first holds off, which stalls the sender
    rx_hold_req = 1'b1;
    run_phase(72, 100, 0, 0);
    run_phase(60, 10, 5, 5);
    run_phase(80, 5, 45, 45);

    // Hold the sender until every response is back
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_rsp.size() != 0);

    quiet = 1'b1;
    run_phase(60, 40, 20, 20);
    quiet = 1'b0;
    run_phase(150, 35, 20, 20);
    run_phase(90, 80, 10, 0);
    run_phase(110, 30, 25, 25);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_rsp.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d responses; receiver held off %0d cycles once.",
             sent, received, RxHoldCycles);
    $display("Saw %0d pops on empty, %0d pushes on full, %0d reads out of range, peak count %0d.",
             empty_pops, full_pushes, range_reads, peak_fill);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  // Sample at the falling edge; the response is taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      received++;
      if (out_data_o.status == StatEmpty) empty_pops++;
      if (out_data_o.status == StatFull) full_pushes++;
      if (out_data_o.status == StatRange) range_reads++;
      if (int'(out_data_o.count) > peak_fill) peak_fill = int'(out_data_o.count);
      if (due_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: response %0d arrived with no request pending", $time, received);
      end else begin
        head_rsp = due_rsp[0];
        due_rsp.delete(0);
        check_field("read_value", head_rsp.read_value, out_data_o.read_value);
        check_field("front_value", head_rsp.front_value, out_data_o.front_value);
        check_field("back_value", head_rsp.back_value, out_data_o.back_value);
        check_field("count", WordBits'(head_rsp.count), WordBits'(out_data_o.count));
        check_field("status", WordBits'(head_rsp.status), WordBits'(out_data_o.status));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("No handshake for %0d cycles, giving up", WatchdogLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
